/* hdl/mmad_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmad_pkg
// Shared widths, constants and inter-module structs for the masked mean
// absolute difference block.
// ----------------------------------------------------------------------------
package mmad_pkg;

  localparam int CH_W   = 32;  // one channel field
  localparam int TERM_W = 33;  // one absolute channel difference, Q.16
  localparam int TSUM_W = 34;  // three channel terms added
  localparam int SUM_W  = 58;  // frame difference accumulator
  localparam int CNT_W  = 23;  // valid pixel counter
  localparam int MEAN_W = 34;  // quotient, Q.16
  localparam int HI_W   = SUM_W - MEAN_W;
  localparam int STEP_W = $clog2(MEAN_W);
  localparam int LANES  = 3;

  localparam logic [CNT_W-1:0]  MAX_PIXELS = CNT_W'(4194304);
  localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};
  localparam logic [MEAN_W-1:0] MEAN_MAX   = {MEAN_W{1'b1}};

  // pixel_mode bit positions
  localparam int MODE_THREE_BIT = 0;
  localparam int MODE_FIXED_BIT = 1;

  typedef struct packed {
    logic valid;
    logic counted;
    logic last;
  } s1_ctrl_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } frame_t;

endpackage

/* hdl/mmad_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmad_lane
// One channel lane: absolute difference of two samples in byte or Q16.16
// form, registered as a Q.16 term.
// ----------------------------------------------------------------------------
module mmad_lane (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          use_ch,
  input  logic                          fixed_mode,
  input  logic signed [mmad_pkg::CH_W-1:0] a,
  input  logic signed [mmad_pkg::CH_W-1:0] b,
  output logic [mmad_pkg::TERM_W-1:0]   term
);
  import mmad_pkg::*;

  logic [CH_W:0]     fx_diff;
  logic [TERM_W-1:0] fx_abs;
  logic [7:0]        byte_abs;
  logic [TERM_W-1:0] byte_term;
  logic [TERM_W-1:0] term_next;

  always_comb begin
    // sign-extend both samples one bit so the difference cannot wrap
    fx_diff   = {a[CH_W-1], a} - {b[CH_W-1], b};
    fx_abs    = fx_diff[CH_W] ? (~fx_diff + TERM_W'(1)) : fx_diff;
    byte_abs  = (a[7:0] >= b[7:0]) ? (a[7:0] - b[7:0]) : (b[7:0] - a[7:0]);
    byte_term = TERM_W'({byte_abs, 16'h0000});
    if (!use_ch) begin
      term_next = '0;
    end else if (fixed_mode) begin
      term_next = fx_abs;
    end else begin
      term_next = byte_term;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      term <= term_next;
    end
  end

endmodule

/* hdl/mmad_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmad_merge
// Merge the lane terms into the saturating frame sum and pixel count; hand
// the frame totals to the divider on the last pixel and clear.
// ----------------------------------------------------------------------------
module mmad_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  mmad_pkg::s1_ctrl_t            s1,
  input  logic                          fire,
  input  logic [mmad_pkg::TERM_W-1:0]   term0,
  input  logic [mmad_pkg::TERM_W-1:0]   term1,
  input  logic [mmad_pkg::TERM_W-1:0]   term2,
  output mmad_pkg::frame_t              frame
);
  import mmad_pkg::*;

  logic [SUM_W-1:0]  diff_sum;
  logic [CNT_W-1:0]  valid_count;
  logic [TSUM_W-1:0] term_sum;
  logic [SUM_W:0]    wide_sum;
  logic              take;
  logic [SUM_W-1:0]  sum_upd;
  logic [CNT_W-1:0]  cnt_upd;

  always_comb begin
    term_sum = TSUM_W'(term0) + TSUM_W'(term1) + TSUM_W'(term2);
    take     = s1.counted && (valid_count < MAX_PIXELS);
    wide_sum = {1'b0, diff_sum} + (SUM_W + 1)'(term_sum);
    if (take) begin
      sum_upd = wide_sum[SUM_W] ? SUM_MAX : wide_sum[SUM_W-1:0];
      cnt_upd = valid_count + CNT_W'(1);
    end else begin
      sum_upd = diff_sum;
      cnt_upd = valid_count;
    end
    frame.start = fire && s1.last;
    frame.sum   = sum_upd;
    frame.count = cnt_upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_sum    <= '0;
      valid_count <= '0;
    end else if (fire) begin
      if (s1.last) begin
        diff_sum    <= '0;
        valid_count <= '0;
      end else begin
        diff_sum    <= sum_upd;
        valid_count <= cnt_upd;
      end
    end
  end

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    valid_count <= MAX_PIXELS)
    else $error("valid pixel count above limit");

endmodule

/* hdl/mmad_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmad_div
// Frame mean: restoring divider, one quotient bit per cycle, with the
// overflow and empty-frame cases resolved at start. Holds the result until
// the output transaction completes.
// ----------------------------------------------------------------------------
module mmad_div (
  input  logic                          clk,
  input  logic                          rst,
  input  mmad_pkg::frame_t              frame,
  output logic                          busy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mmad_pkg::MEAN_W-1:0]   mean_diff,
  output logic [mmad_pkg::CNT_W-1:0]    valid_pixels,
  output logic                          no_valid
);
  import mmad_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } div_state_t;

  div_state_t        state;
  logic [CNT_W-1:0]  divisor;
  logic [CNT_W-1:0]  rem;
  logic [MEAN_W-1:0] dq;
  logic [STEP_W-1:0] step;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    trial_sub;
  logic              ge;
  logic [CNT_W-1:0]  rem_next;
  logic [MEAN_W-1:0] dq_next;

  always_comb begin
    trial     = {rem, dq[MEAN_W-1]};
    trial_sub = trial - {1'b0, divisor};
    ge        = trial >= {1'b0, divisor};
    rem_next  = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    dq_next   = {dq[MEAN_W-2:0], ge};
  end

  assign busy      = (state != ST_IDLE);
  assign out_valid = (state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (frame.start) begin
            divisor      <= frame.count;
            valid_pixels <= frame.count;
            if (frame.count == '0) begin
              mean_diff <= '0;
              no_valid  <= 1'b1;
              state     <= ST_DONE;
            end else if (frame.sum[SUM_W-1:MEAN_W] >= HI_W'(frame.count)) begin
              // quotient would need more than MEAN_W bits
              mean_diff <= MEAN_MAX;
              no_valid  <= 1'b0;
              state     <= ST_DONE;
            end else begin
              rem   <= frame.sum[MEAN_W+CNT_W-1:MEAN_W];
              dq    <= frame.sum[MEAN_W-1:0];
              step  <= STEP_W'(MEAN_W - 1);
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          rem <= rem_next;
          dq  <= dq_next;
          if (step == '0) begin
            mean_diff <= dq_next;
            no_valid  <= 1'b0;
            state     <= ST_DONE;
          end else begin
            step <= step - STEP_W'(1);
          end
        end
        ST_DONE: begin
          if (out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    frame.start |-> state == ST_IDLE)
    else $error("frame handed off while divider busy");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> rem < divisor)
    else $error("partial remainder not below divisor");

  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && no_valid) |-> (mean_diff == '0 && valid_pixels == '0))
    else $error("empty frame result carries nonzero fields");

endmodule

/* hdl/masked_mean_abs_difference.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_mean_abs_difference
// Masked mean absolute difference of two co-located pixel streams, one
// mean per frame in unsigned Q.16.
// ----------------------------------------------------------------------------
// Pixel pairs are taken one per cycle for the whole frame, except while a
// frame_end pixel waits for the divider. Three channel lanes register the
// absolute differences, and a merge stage adds them into a 58-bit saturating
// sum and a pixel counter. When the frame_end pixel reaches the merge stage,
// the frame totals pass to a restoring divider that produces one quotient
// bit per cycle; an empty frame or a saturated mean goes straight to the
// result without dividing. Pixels of the next frame keep streaming in while
// the divider runs; only the next frame_end pixel holds in the merge stage,
// blocking input, until the divider is free and its result has been taken.
// Mono modes use channel 0 only; byte modes use the low 8 bits of each
// channel, scaled by 2^16. pixel_mode may only be written between frames
// with no result pending.
// ----------------------------------------------------------------------------
module masked_mean_abs_difference (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [1:0]                       cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [mmad_pkg::CH_W-1:0] a_ch0,
  input  logic signed [mmad_pkg::CH_W-1:0] a_ch1,
  input  logic signed [mmad_pkg::CH_W-1:0] a_ch2,
  input  logic signed [mmad_pkg::CH_W-1:0] b_ch0,
  input  logic signed [mmad_pkg::CH_W-1:0] b_ch1,
  input  logic signed [mmad_pkg::CH_W-1:0] b_ch2,
  input  logic [7:0]                       mask_byte,
  input  logic                             frame_end,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mmad_pkg::MEAN_W-1:0]      mean_diff,
  output logic [mmad_pkg::CNT_W-1:0]       valid_pixels,
  output logic                             no_valid
);
  import mmad_pkg::*;

  logic [1:0]        pixel_mode;
  s1_ctrl_t          s1;
  logic              accept;
  logic              fire;
  logic              div_busy;
  frame_t            frame;
  logic [CH_W-1:0]   a_arr [LANES];
  logic [CH_W-1:0]   b_arr [LANES];
  logic [LANES-1:0]  use_ch;
  logic [TERM_W-1:0] term [LANES];

  // mode register: the user must write it only between frames; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode <= 2'b00;
    end else if (cfg_wr_en) begin
      pixel_mode <= cfg_wr_data;
    end
  end

  // hold a frame_end pixel in the merge stage until the divider is free
  assign fire     = s1.valid && !(s1.last && div_busy);
  assign in_ready = !s1.valid || fire;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (accept) begin
      s1.valid   <= 1'b1;
      s1.counted <= (mask_byte != 8'h00);
      s1.last    <= frame_end;
    end else if (fire) begin
      s1.valid <= 1'b0;
    end
  end

  assign a_arr[0] = a_ch0;
  assign a_arr[1] = a_ch1;
  assign a_arr[2] = a_ch2;
  assign b_arr[0] = b_ch0;
  assign b_arr[1] = b_ch1;
  assign b_arr[2] = b_ch2;

  // channel 0 always counts; channels 1 and 2 only in three-channel modes
  assign use_ch = {pixel_mode[MODE_THREE_BIT], pixel_mode[MODE_THREE_BIT], 1'b1};

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    mmad_lane u_lane (
      .clk        (clk),
      .load       (accept),
      .use_ch     (use_ch[i]),
      .fixed_mode (pixel_mode[MODE_FIXED_BIT]),
      .a          (a_arr[i]),
      .b          (b_arr[i]),
      .term       (term[i])
    );
  end

  mmad_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .s1    (s1),
    .fire  (fire),
    .term0 (term[0]),
    .term1 (term[1]),
    .term2 (term[2]),
    .frame (frame)
  );

  mmad_div u_div (
    .clk          (clk),
    .rst          (rst),
    .frame        (frame),
    .busy         (div_busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mean_diff    (mean_diff),
    .valid_pixels (valid_pixels),
    .no_valid     (no_valid)
  );

endmodule
